@@ design/btn_ar_pkg.sv @@
// btn_ar_pkg: shared types, constants and lane codes for the button auto-repeat block
// no dependencies; used by every design file of the block
// lane order is the scan priority: up, down, right, left, R1, L1
package btn_ar_pkg;

    localparam int BTN_W      = 16;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CTR_W      = 10;
    localparam int LANE_COUNT = 6;
    localparam int DIR_LANES  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_PERIOD = 2'd2;

    localparam logic [BTN_W-1:0] LANE_CODES [LANE_COUNT] = '{
        16'h1000, 16'h4000, 16'h2000, 16'h8000, 16'h0008, 16'h0004
    };

    typedef enum logic [1:0] {
        LANE_KEEP = 2'd0,
        LANE_INC  = 2'd1,
        LANE_ZERO = 2'd2,
        LANE_FIRE = 2'd3
    } t_lane_op;

    typedef struct packed {
        logic active;
        logic held;
        logic fire;
    } t_lane_stat;

endpackage

@@ design/btn_ar_if.sv @@
// btn_ar_if: valid/ready channel interfaces for input ticks, results and config writes
// depends on btn_ar_pkg for field widths
// each interface has a source and a sink modport
interface btn_ar_in_if;
    logic                          valid;
    logic                          ready;
    logic [btn_ar_pkg::BTN_W-1:0]  interest_mask;
    logic [btn_ar_pkg::BTN_W-1:0]  new_presses;
    logic [btn_ar_pkg::BTN_W-1:0]  held_buttons;

    modport source (output valid, interest_mask, new_presses, held_buttons, input ready);
    modport sink   (input valid, interest_mask, new_presses, held_buttons, output ready);
endinterface

interface btn_ar_out_if;
    logic                          valid;
    logic                          ready;
    logic [btn_ar_pkg::BTN_W-1:0]  result_mask;

    modport source (output valid, result_mask, input ready);
    modport sink   (input valid, result_mask, output ready);
endinterface

interface btn_ar_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [btn_ar_pkg::CFG_IDX_W-1:0]  index;
    logic [btn_ar_pkg::CFG_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/button_auto_repeat_top.sv @@
// Button auto-repeat: one input transaction is one tick and gives exactly one result
// transaction. Six counter lanes (up, down, right, left, R1, L1) evaluate in parallel
// and a priority merge picks the first repeat; an item is taken every cycle while the
// skid entry is empty, registered in the output register or, on a stall, the skid entry.
// Config writes take effect on the next tick; the config channel is always ready.
// depends on btn_ar_pkg, btn_ar_if, btn_ar_lane and btn_ar_merge
module button_auto_repeat_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    btn_ar_in_if.sink     i_in,
    btn_ar_cfg_if.sink    i_cfg,
    btn_ar_out_if.source  o_out
);

    logic [btn_ar_pkg::CFG_W-1:0] r_initial_delay;
    logic [btn_ar_pkg::CFG_W-1:0] r_repeat_period;
    logic [btn_ar_pkg::CFG_W-1:0] r_shoulder_period;

    logic                         r_out_valid;
    logic [btn_ar_pkg::BTN_W-1:0] r_out_data;
    logic                         r_skid_valid;
    logic [btn_ar_pkg::BTN_W-1:0] r_skid_data;

    logic                         w_accept;
    logic                         w_pop;
    logic [btn_ar_pkg::BTN_W-1:0] w_pressed;
    logic [btn_ar_pkg::BTN_W-1:0] w_result;

    btn_ar_pkg::t_lane_stat [btn_ar_pkg::LANE_COUNT-1:0] w_stat;
    btn_ar_pkg::t_lane_op   [btn_ar_pkg::LANE_COUNT-1:0] w_op;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay   <= 8'd0;
            r_repeat_period   <= 8'd1;
            r_shoulder_period <= 8'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                btn_ar_pkg::REG_INITIAL_DELAY:   r_initial_delay   <= i_cfg.data;
                btn_ar_pkg::REG_REPEAT_PERIOD:   r_repeat_period   <= i_cfg.data;
                btn_ar_pkg::REG_SHOULDER_PERIOD: r_shoulder_period <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && !r_skid_valid;
    assign w_pop      = r_out_valid && o_out.ready;
    assign w_pressed  = i_in.new_presses & i_in.interest_mask;

    for (genvar g = 0; g < btn_ar_pkg::LANE_COUNT; g++) begin : g_lane
        btn_ar_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (|(i_in.interest_mask & btn_ar_pkg::LANE_CODES[g])),
            .i_held   (|(i_in.held_buttons & btn_ar_pkg::LANE_CODES[g])),
            .i_delay  (r_initial_delay),
            .i_period ((g < btn_ar_pkg::DIR_LANES) ? r_repeat_period : r_shoulder_period),
            .i_op     (w_op[g]),
            .o_stat   (w_stat[g])
        );
    end

    btn_ar_merge u_merge (
        .i_accept (w_accept),
        .i_pressed(w_pressed),
        .i_stat   (w_stat),
        .o_op     (w_op),
        .o_result (w_result)
    );

    // output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_pop) begin
                r_out_data <= w_result;
            end else begin
                r_skid_data <= w_result;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_mask = r_out_data;

endmodule

@@ design/btn_ar_lane.sv @@
// btn_ar_lane: one button's repeat counter with its increment, threshold and period logic
// depends on btn_ar_pkg; the update op comes from btn_ar_merge
module btn_ar_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_active,
    input  logic                          i_held,
    input  logic [btn_ar_pkg::CFG_W-1:0]  i_delay,
    input  logic [btn_ar_pkg::CFG_W-1:0]  i_period,
    input  btn_ar_pkg::t_lane_op          i_op,
    output btn_ar_pkg::t_lane_stat        o_stat
);

    logic signed [btn_ar_pkg::CTR_W-1:0] r_count;
    logic signed [btn_ar_pkg::CTR_W-1:0] n_count;
    logic signed [btn_ar_pkg::CTR_W-1:0] w_next;
    logic signed [btn_ar_pkg::CTR_W-1:0] w_delay;
    logic signed [btn_ar_pkg::CTR_W-1:0] w_period;
    logic        [btn_ar_pkg::CFG_W-1:0] w_period_eff;

    assign w_next       = r_count + 10'sd1;
    assign w_delay      = $signed({2'b00, i_delay});
    // a zero period behaves as one
    assign w_period_eff = (i_period == '0) ? 8'd1 : i_period;
    assign w_period     = $signed({2'b00, w_period_eff});

    assign o_stat.active = i_active;
    assign o_stat.held   = i_held;
    assign o_stat.fire   = i_active && i_held && (w_next > w_delay);

    always_comb begin
        case (i_op)
            btn_ar_pkg::LANE_KEEP: n_count = r_count;
            btn_ar_pkg::LANE_INC:  n_count = w_next;
            btn_ar_pkg::LANE_ZERO: n_count = '0;
            btn_ar_pkg::LANE_FIRE: n_count = w_next - w_period;
            default:               n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

@@ design/btn_ar_merge.sv @@
// btn_ar_merge: priority pick over the lane results and per-lane update ops
// depends on btn_ar_pkg; drives btn_ar_lane ops and the result word
module btn_ar_merge (
    input  logic                                                   i_accept,
    input  logic [btn_ar_pkg::BTN_W-1:0]                           i_pressed,
    input  btn_ar_pkg::t_lane_stat [btn_ar_pkg::LANE_COUNT-1:0]    i_stat,
    output btn_ar_pkg::t_lane_op   [btn_ar_pkg::LANE_COUNT-1:0]    o_op,
    output logic [btn_ar_pkg::BTN_W-1:0]                           o_result
);

    logic found;

    always_comb begin
        found    = 1'b0;
        o_result = '0;
        for (int i = 0; i < btn_ar_pkg::LANE_COUNT; i++) begin
            o_op[i] = btn_ar_pkg::LANE_KEEP;
        end
        if (i_pressed != '0) begin
            o_result = i_pressed;
            // a new press clears only the direction counters
            for (int i = 0; i < btn_ar_pkg::DIR_LANES; i++) begin
                o_op[i] = btn_ar_pkg::LANE_ZERO;
            end
        end else begin
            for (int i = 0; i < btn_ar_pkg::LANE_COUNT; i++) begin
                if (!found && i_stat[i].active) begin
                    if (i_stat[i].fire) begin
                        found    = 1'b1;
                        o_op[i]  = btn_ar_pkg::LANE_FIRE;
                        o_result = btn_ar_pkg::LANE_CODES[i];
                    end else if (i_stat[i].held) begin
                        o_op[i] = btn_ar_pkg::LANE_INC;
                    end else begin
                        o_op[i] = btn_ar_pkg::LANE_ZERO;
                    end
                end
            end
        end
        if (!i_accept) begin
            for (int i = 0; i < btn_ar_pkg::LANE_COUNT; i++) begin
                o_op[i] = btn_ar_pkg::LANE_KEEP;
            end
        end
    end

endmodule

@@ design/btn_ar_check.sv @@
// btn_ar_check: port-level assertions for the button auto-repeat top level
// depends on btn_ar_pkg; bound to button_auto_repeat_top below
module btn_ar_check (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic [btn_ar_pkg::BTN_W-1:0] i_mask,
    input logic [btn_ar_pkg::BTN_W-1:0] i_new,
    input logic [btn_ar_pkg::BTN_W-1:0] i_held,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [btn_ar_pkg::BTN_W-1:0] i_result
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result))
        else $error("result changed or dropped while stalled");

    // input backpressure only when a result is waiting
    a_ready_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    // a masked new press is returned as is
    a_press_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid && ((i_new & i_mask) != '0)
        |=> i_out_valid && (i_result == $past(i_new & i_mask)))
        else $error("new press not returned");

    // nothing held and nothing pressed gives a zero result
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid && ((i_new & i_mask) == '0)
        && ((i_held & i_mask) == '0)
        |=> i_out_valid && (i_result == '0))
        else $error("repeat fired without held button");

endmodule

bind button_auto_repeat_top btn_ar_check u_btn_ar_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in.valid),
    .i_in_ready (i_in.ready),
    .i_mask     (i_in.interest_mask),
    .i_new      (i_in.new_presses),
    .i_held     (i_in.held_buttons),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_result   (o_out.result_mask)
);
